[hw/rtl/lpmd_pkg.sv]
// ----------------------------------------------------------------------------
// lpmd_pkg
// shared types and constants of the length prefixed message deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned OFFSET_W = 24;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned LCNT_W   = 2;

	localparam logic [OFFSET_W-1:0] MAX_LEN_RESET = 24'd4092;
	localparam logic [LEN_W-1:0]    HDR_SIZE      = 32'd18;
	localparam logic [LEN_W-1:0]    CORR_FIRST    = 32'd2;
	localparam logic [LCNT_W-1:0]   LCNT_LAST     = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_COMMAND  = 3'd0,
		KIND_FLAGS    = 3'd1,
		KIND_CORR     = 3'd2,
		KIND_BODY     = 3'd3,
		KIND_EMPTY    = 3'd4,
		KIND_OVERSIZE = 3'd5
	} kind_t;

endpackage

`default_nettype wire

[hw/rtl/lpmd_if.sv]
// ----------------------------------------------------------------------------
// lpmd channel interfaces
// byte stream channel and tagged result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lpmd_byte_if;
	logic                             valid;
	logic                             ready;
	logic [lpmd_pkg::BYTE_W-1:0]      stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpmd_result_if;
	logic                             valid;
	logic                             ready;
	logic [lpmd_pkg::KIND_W-1:0]      item_kind;
	logic [lpmd_pkg::BYTE_W-1:0]      payload_byte;
	logic [lpmd_pkg::OFFSET_W-1:0]    frame_offset;
	logic                             frame_last;
	logic                             short_header;

	modport source (output valid, output item_kind, output payload_byte,
		output frame_offset, output frame_last, output short_header, input ready);
	modport sink   (input valid, input item_kind, input payload_byte,
		input frame_offset, input frame_last, input short_header, output ready);
endinterface

`default_nettype wire

[hw/rtl/length_prefix_message_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_prefix_message_deframer_unit
// splits a byte stream of 32-bit little-endian length prefixed frames into
// tagged payload items, with empty and oversize frame markers
//
//   channel    dir   payload                                       handshake
//   stream     in    stream_byte[7:0]                              valid/ready
//   result     out   item_kind, payload_byte, frame_offset,        valid/ready
//                    frame_last, short_header
//   cfg        in    cfg_wdata[23:0] -> max_frame_length           cfg_wen
//
// one byte per cycle while stream ready is high; each byte updates the frame counters and its result
// is registered in the output stage, so a result appears in the next cycle
// stream ready is low only while a result is held and result ready is low
// arst_n clears frame state and restores max_frame_length to 4092
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_message_deframer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	lpmd_byte_if.sink                              stream,
	lpmd_result_if.source                          result,
	input  wire logic                              cfg_wen,
	input  wire logic [lpmd_pkg::OFFSET_W-1:0]     cfg_wdata
);

	logic [lpmd_pkg::OFFSET_W-1:0] max_len_q;
	logic                          in_payload_q;
	logic [lpmd_pkg::LCNT_W-1:0]   lcnt_q;
	logic [lpmd_pkg::LEN_W-1:0]    len_q;
	logic [lpmd_pkg::LEN_W-1:0]    pos_q;
	logic                          skip_q;

	logic                          out_valid_q;
	lpmd_pkg::kind_t               kind_q;
	logic [lpmd_pkg::BYTE_W-1:0]   byte_q;
	logic [lpmd_pkg::OFFSET_W-1:0] offset_q;
	logic                          last_q;
	logic                          short_q;

	logic                          accept;
	logic [lpmd_pkg::LEN_W-1:0]    len_asm;
	logic [lpmd_pkg::LEN_W:0]      pos_inc;
	logic                          pay_last;
	logic                          emit;
	lpmd_pkg::kind_t               kind_d;
	logic [lpmd_pkg::BYTE_W-1:0]   byte_d;
	logic [lpmd_pkg::OFFSET_W-1:0] offset_d;
	logic                          last_d;
	logic                          short_d;

	assign accept       = stream.valid && stream.ready;
	assign stream.ready = !out_valid_q || result.ready;

	// length assembly, least significant byte first
	always_comb begin
		unique case (lcnt_q)
			2'd0: len_asm = {24'd0, stream.stream_byte};
			2'd1: len_asm = len_q | {16'd0, stream.stream_byte, 8'd0};
			2'd2: len_asm = len_q | {8'd0, stream.stream_byte, 16'd0};
			default: len_asm = len_q | {stream.stream_byte, 24'd0};
		endcase
	end

	assign pos_inc  = {1'b0, pos_q} + {{lpmd_pkg::LEN_W{1'b0}}, 1'b1};
	assign pay_last = pos_inc >= {1'b0, len_q};

	always_comb begin
		emit     = 1'b0;
		kind_d   = lpmd_pkg::KIND_BODY;
		byte_d   = '0;
		offset_d = '0;
		last_d   = 1'b1;
		short_d  = 1'b0;
		if (!in_payload_q) begin
			short_d = len_asm < lpmd_pkg::HDR_SIZE;
			if (lcnt_q == lpmd_pkg::LCNT_LAST) begin
				if (len_asm == '0) begin
					emit   = 1'b1;
					kind_d = lpmd_pkg::KIND_EMPTY;
				end else if (len_asm > {8'd0, max_len_q}) begin
					emit   = 1'b1;
					kind_d = lpmd_pkg::KIND_OVERSIZE;
				end
			end
		end else begin
			emit     = !skip_q;
			byte_d   = stream.stream_byte;
			offset_d = pos_q[lpmd_pkg::OFFSET_W-1:0];
			last_d   = pay_last;
			short_d  = len_q < lpmd_pkg::HDR_SIZE;
			priority if (pos_q == '0) begin
				kind_d = lpmd_pkg::KIND_COMMAND;
			end else if (pos_q == 32'd1) begin
				kind_d = lpmd_pkg::KIND_FLAGS;
			end else if (pos_q >= lpmd_pkg::CORR_FIRST && pos_q < lpmd_pkg::HDR_SIZE) begin
				kind_d = lpmd_pkg::KIND_CORR;
			end else begin
				kind_d = lpmd_pkg::KIND_BODY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lpmd_pkg::MAX_LEN_RESET;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			lcnt_q       <= '0;
			len_q        <= '0;
			pos_q        <= '0;
			skip_q       <= 1'b0;
		end else if (accept) begin
			if (!in_payload_q) begin
				len_q <= len_asm;
				if (lcnt_q == lpmd_pkg::LCNT_LAST) begin
					lcnt_q <= '0;
					pos_q  <= '0;
					if (len_asm != '0) begin
						in_payload_q <= 1'b1;
						skip_q       <= len_asm > {8'd0, max_len_q};
					end
				end else begin
					lcnt_q <= lcnt_q + 2'd1;
				end
			end else if (pay_last) begin
				in_payload_q <= 1'b0;
				pos_q        <= '0;
				skip_q       <= 1'b0;
			end else begin
				pos_q <= pos_inc[lpmd_pkg::LEN_W-1:0];
			end
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q   <= kind_d;
			byte_q   <= byte_d;
			offset_q <= offset_d;
			last_q   <= last_d;
			short_q  <= short_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.item_kind    = kind_q;
	assign result.payload_byte = byte_q;
	assign result.frame_offset = offset_q;
	assign result.frame_last   = last_q;
	assign result.short_header = short_q;

endmodule

`default_nettype wire

[sim/length_prefix_message_deframer_unit_tb.sv]
// ----------------------------------------------------------------------------
// length_prefix_message_deframer_unit_tb
// feeds length prefixed frames byte by byte through the deframer under random
// idling on both channels (off from the back-to-back test on), predicts every tagged item and marker from its own
// copy of the frame counters, and checks each result item in order
// ----------------------------------------------------------------------------
module length_prefix_message_deframer_unit_tb;

	localparam int STALL_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 8;

	typedef struct packed {
		lpmd_pkg::kind_t                kind;
		logic [lpmd_pkg::BYTE_W-1:0]    data;
		logic [lpmd_pkg::OFFSET_W-1:0]  offset;
		logic                           last;
		logic                           shorth;
	} tagged_item_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wen;
	logic [lpmd_pkg::OFFSET_W-1:0] cfg_wdata;

	lpmd_byte_if   stream_ch ();
	lpmd_result_if result_ch ();

	length_prefix_message_deframer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_ch),
		.result    (result_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	logic                          in_payload;
	logic [lpmd_pkg::LCNT_W-1:0]   length_count;
	logic [lpmd_pkg::LEN_W-1:0]    frame_length;
	logic [lpmd_pkg::LEN_W-1:0]    payload_pos;
	logic                          skipping;
	logic [lpmd_pkg::OFFSET_W-1:0] capacity;

	tagged_item_t tagged_items[$];
	tagged_item_t next_item;
	tagged_item_t want_item;
	logic         emit;
	int           mismatch_count;
	int           stall_cycles;
	int           sink_hold;
	bit           idle_on;
	bit           src_quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void deframe_byte(input logic [lpmd_pkg::BYTE_W-1:0] b,
		output logic produced, output tagged_item_t it);
		logic [lpmd_pkg::LEN_W-1:0] cur;
		logic                       last;
		produced = 1'b0;
		it       = '0;
		if (!in_payload) begin
			if (length_count == '0)
				frame_length = {24'd0, b};
			else
				frame_length = frame_length | ({24'd0, b} << (8 * length_count));
			if (length_count != lpmd_pkg::LCNT_LAST) begin
				length_count = length_count + 1'b1;
				return;
			end
			length_count = '0;
			payload_pos  = '0;
			it.shorth    = frame_length < lpmd_pkg::HDR_SIZE;
			it.last      = 1'b1;
			if (frame_length == '0) begin
				produced = 1'b1;
				it.kind  = lpmd_pkg::KIND_EMPTY;
				return;
			end
			in_payload = 1'b1;
			if (frame_length > {8'd0, capacity}) begin
				skipping = 1'b1;
				produced = 1'b1;
				it.kind  = lpmd_pkg::KIND_OVERSIZE;
				return;
			end
			skipping = 1'b0;
			return;
		end
		cur  = payload_pos;
		last = ({1'b0, cur} + 33'd1) >= {1'b0, frame_length};
		if (last) begin
			in_payload  = 1'b0;
			payload_pos = '0;
		end else begin
			payload_pos = cur + 1;
		end
		if (skipping) begin
			if (last)
				skipping = 1'b0;
			return;
		end
		if (cur == 0)
			it.kind = lpmd_pkg::KIND_COMMAND;
		else if (cur == 1)
			it.kind = lpmd_pkg::KIND_FLAGS;
		else if (cur >= lpmd_pkg::CORR_FIRST && cur < lpmd_pkg::HDR_SIZE)
			it.kind = lpmd_pkg::KIND_CORR;
		else
			it.kind = lpmd_pkg::KIND_BODY;
		produced  = 1'b1;
		it.data   = b;
		it.offset = cur[lpmd_pkg::OFFSET_W-1:0];
		it.last   = last;
		it.shorth = frame_length < lpmd_pkg::HDR_SIZE;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_item(input tagged_item_t want);
		if (result_ch.item_kind !== want.kind)
			report_mismatch("item_kind", result_ch.item_kind, want.kind);
		if (result_ch.payload_byte !== want.data)
			report_mismatch("payload_byte", result_ch.payload_byte, want.data);
		if (result_ch.frame_offset !== want.offset)
			report_mismatch("frame_offset", result_ch.frame_offset, want.offset);
		if (result_ch.frame_last !== want.last)
			report_mismatch("frame_last", result_ch.frame_last, want.last);
		if (result_ch.short_header !== want.shorth)
			report_mismatch("short_header", result_ch.short_header, want.shorth);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_payload   = 1'b0;
			length_count = '0;
			frame_length = '0;
			payload_pos  = '0;
			skipping     = 1'b0;
			capacity     = lpmd_pkg::MAX_LEN_RESET;
			tagged_items.delete();
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (tagged_items.size() == 0) begin
					report_mismatch("unexpected item, kind", result_ch.item_kind, '0);
				end else begin
					want_item = tagged_items.pop_front();
					check_item(want_item);
				end
			end
			if (cfg_wen)
				capacity = cfg_wdata;
			if (stream_ch.valid && stream_ch.ready) begin
				deframe_byte(stream_ch.stream_byte, emit, next_item);
				if (emit)
					tagged_items.push_back(next_item);
			end
		end
	end

	initial begin
		result_ch.ready <= 1'b0;
		sink_hold = 0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				sink_hold = $urandom_range(0, 13);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (stream_ch.valid && stream_ch.ready) ||
				(result_ch.valid && result_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("length_prefix_message_deframer_unit: mismatch");
		$finish;
	end

	task automatic send_byte(input logic [lpmd_pkg::BYTE_W-1:0] b);
		if (idle_on && !src_quiet && $urandom_range(0, 9) == 0) begin
			stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		stream_ch.valid       <= 1'b1;
		stream_ch.stream_byte <= b;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_length(input logic [lpmd_pkg::LEN_W-1:0] len);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
	endtask

	task automatic send_frame(input logic [lpmd_pkg::LEN_W-1:0] len);
		send_length(len);
		for (int unsigned i = 0; i < len; i++)
			send_byte($urandom_range(0, 255));
	endtask

	task automatic send_random_frames(input int budget, input int lo, input int hi);
		int                         sent;
		logic [lpmd_pkg::LEN_W-1:0] len;
		sent = 0;
		while (sent < budget) begin
			len = $urandom_range(lo, hi);
			if ($urandom_range(0, 7) == 0)
				len = '0;
			src_quiet = ($urandom_range(0, 3) == 0);
			send_frame(len);
			sent += len + 4;
		end
		src_quiet = 1'b0;
	endtask

	task automatic set_capacity(input logic [lpmd_pkg::OFFSET_W-1:0] value);
		stream_ch.valid <= 1'b0;
		@(posedge clk);
		while (tagged_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// empty, one byte and two byte frames at the reset capacity
	task automatic test_directed_frames();
		send_length(32'd0);
		send_length(32'd1);
		send_byte(8'hFF);
		send_length(32'd2);
		send_byte(8'h00);
		send_byte(8'h80);
	endtask

	// every non-empty frame is oversize
	task automatic test_zero_capacity();
		set_capacity('0);
		send_length(32'd1);
		send_byte(8'hAA);
		send_length(32'd0);
	endtask

	task automatic test_header_fields();
		set_capacity('1);
		send_random_frames(180, 0, 40);
	endtask

	task automatic test_capacity_boundary();
		set_capacity(24'd20);
		send_random_frames(150, 14, 26);
		send_frame($urandom_range(30, 60));
		send_frame(32'd21);
		send_frame(32'd20);
	endtask

	task automatic test_single_byte_capacity();
		set_capacity(24'd1);
		send_random_frames(120, 0, 3);
	endtask

	task automatic test_random_capacity();
		repeat (5) begin
			set_capacity($urandom_range(0, 64));
			send_random_frames(30, 0, 40);
		end
	endtask

	task automatic test_long_frames();
		set_capacity(lpmd_pkg::MAX_LEN_RESET);
		send_frame($urandom_range(256, 280));
		send_random_frames(60, 0, 30);
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		set_capacity(24'd30);
		send_random_frames(150, 0, 40);
	endtask

	// largest possible length, payload is skipped for the rest of the run
	task automatic test_huge_length();
		set_capacity('1);
		send_length('1);
		repeat (8) send_byte($urandom_range(0, 255));
	endtask

	initial begin
		arst_n                <= 1'b0;
		cfg_wen               <= 1'b0;
		cfg_wdata             <= '0;
		stream_ch.valid       <= 1'b0;
		stream_ch.stream_byte <= '0;
		idle_on        = 1'b1;
		src_quiet      = 1'b0;
		mismatch_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_zero_capacity();
		test_header_fields();
		test_capacity_boundary();
		test_single_byte_capacity();
		test_random_capacity();
		test_long_frames();
		test_back_to_back();
		test_huge_length();

		stream_ch.valid <= 1'b0;
		@(posedge clk);
		while (tagged_items.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("length_prefix_message_deframer_unit: match");
		else
			$display("length_prefix_message_deframer_unit: mismatch");
		$finish;
	end

endmodule
